### rtl/core/multi_head_attention_forward_core_assert.svh
// Assertion macros for the attention core.
// Included by the top level; relies on clk and rst in the including module.
`ifndef MULTI_HEAD_ATTENTION_FORWARD_CORE_ASSERT_SVH
`define MULTI_HEAD_ATTENTION_FORWARD_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define MHAF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MHAF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/mhaf_pkg.sv
// Shared types, constants and the exp table of the attention core.
// Depends on nothing; used by mhaf_div and the top-level core.
package mhaf_pkg;

  localparam int MAX_SEQ         = 64;
  localparam int MAX_CHANNELS    = 256;
  localparam int MAX_HEADS       = 16;
  localparam int EXP_TABLE_DEPTH = 256;

  localparam int QKV_DEPTH = MAX_SEQ * 3 * MAX_CHANNELS;
  localparam int OUT_DEPTH = MAX_SEQ * MAX_CHANNELS;
  localparam int QKV_AW    = $clog2(QKV_DEPTH);
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int SEQ_AW    = $clog2(MAX_SEQ);
  localparam int HDIM_AW   = $clog2(MAX_CHANNELS);
  localparam int CH_W      = $clog2(MAX_CHANNELS + 1);
  localparam int EXP_IDX_W = $clog2(EXP_TABLE_DEPTH);

  localparam int SCORE_W   = 32;
  localparam int EXP_ONE_W = 17;
  localparam int SUM_W     = EXP_ONE_W + SEQ_AW;
  localparam int DIV_NUM_W = EXP_ONE_W + 16;
  localparam int DIV_DEN_W = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;

  localparam logic [95:0] EXP_STEP_RATIO = 96'd4034748381;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_RUN  = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_CFG = 2'd1,
    STATUS_RANGE   = 2'd2
  } status_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_SEQ_LEN     = 2'd0,
    REG_CHANNELS    = 2'd1,
    REG_HEAD_COUNT  = 2'd2,
    REG_SCORE_SCALE = 2'd3
  } reg_index_t;

  typedef struct packed {
    func_t              func;
    logic [15:0]        elem_index;
    logic signed [15:0] elem_value;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] out_value;
    status_t            status;
  } out_word_t;

  typedef logic [EXP_ONE_W-1:0] exp_tab_t [EXP_TABLE_DEPTH];

  // exp(-i/16) in unsigned Q1.16, built by repeated multiplication with a rounded ratio.
  function automatic exp_tab_t build_exp_table();
    exp_tab_t    tab;
    logic [95:0] x;
    x = 96'd1 << 32;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      tab[i] = EXP_ONE_W'((x + 96'd32768) >> 16);
      x = ((x * EXP_STEP_RATIO) + (96'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage

### rtl/core/mhaf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module mhaf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/mhaf_div.sv
// Restoring divider, one quotient bit per cycle, shared by the core.
// Depends on mhaf_pkg for its widths.
module mhaf_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [mhaf_pkg::DIV_NUM_W-1:0] num,
  input  logic [mhaf_pkg::DIV_DEN_W-1:0] den,
  output logic                           busy,
  output logic                           done,
  output logic [mhaf_pkg::DIV_NUM_W-1:0] quo,
  output logic [mhaf_pkg::DIV_DEN_W-1:0] rem
);

  logic [mhaf_pkg::DIV_DEN_W-1:0] den_reg;
  logic [mhaf_pkg::DIV_CNT_W-1:0] count;
  logic [mhaf_pkg::DIV_DEN_W:0]   trial;
  logic                           fits;

  assign trial = {rem, quo[mhaf_pkg::DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        quo     <= num;
        den_reg <= den;
        rem     <= '0;
        count   <= mhaf_pkg::DIV_CNT_W'(mhaf_pkg::DIV_NUM_W);
      end else if (busy) begin
        rem   <= fits ? mhaf_pkg::DIV_DEN_W'(trial - {1'b0, den_reg})
                      : trial[mhaf_pkg::DIV_DEN_W-1:0];
        quo   <= {quo[mhaf_pkg::DIV_NUM_W-2:0], fits};
        count <= count - 1'b1;
        if (count == mhaf_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/multi_head_attention_forward_core.sv
// Multi-head scaled dot-product attention core: load, run and read sequencer.
// Depends on mhaf_pkg, mhaf_ram, mhaf_div and the assertion macro header.
//
// Usage. Input words arrive on in_valid/in_ready, result words leave on
// out_valid/out_ready; both are taken when valid and ready are high together.
// A load word writes one Q,K,V element and is answered in the next cycle; loads
// go at one word per cycle while out_ready stays high. A valid read word is
// answered once the output memory's registered read data has passed into the
// output register. A run word holds the input side until the whole computation
// is done; its running time is set by the single read port of the Q,K,V memory
// and the bit-serial weight divider. The answer is registered on the same edge
// that writes the last output element. Function code three is taken and not
// answered. Configuration writes are taken at any cycle; after each one the
// block checks the setting (with the same divider), during which in_ready is
// low. Reset runs that check once for the reset values; the data
// memories are not cleared. A result waits in the output register while the
// receiver stalls, and a new word is taken only once that register is free
// or being emptied in the same cycle.
module multi_head_attention_forward_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mhaf_pkg::in_word_t          in_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mhaf_pkg::out_word_t         out_word,
  input  logic                        cfg_wr_en,
  input  logic [mhaf_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [mhaf_pkg::CFG_DW-1:0] cfg_wr_data
);

  typedef enum logic [16:0] {
    S_IDLE   = 17'b00000000000000001,
    S_CHK    = 17'b00000000000000010,
    S_CHKW   = 17'b00000000000000100,
    S_READ   = 17'b00000000000001000,
    S_Q      = 17'b00000000000010000,
    S_K      = 17'b00000000000100000,
    S_MAC    = 17'b00000000001000000,
    S_SC1    = 17'b00000000010000000,
    S_SC2    = 17'b00000000100000000,
    S_EXP_RD = 17'b00000001000000000,
    S_EXP    = 17'b00000010000000000,
    S_W_RD   = 17'b00000100000000000,
    S_W_DIV  = 17'b00001000000000000,
    S_W_WAIT = 17'b00010000000000000,
    S_O_RD   = 17'b00100000000000000,
    S_O_MAC  = 17'b01000000000000000,
    S_O_WR   = 17'b10000000000000000
  } state_t;

  state_t state;

  // Configuration and derived values.
  logic [6:0]                      seq_len;
  logic [8:0]                      channels;
  logic [4:0]                      head_count;
  logic [15:0]                     score_scale;
  logic                            cfg_dirty;
  logic                            cfg_ok;
  logic [mhaf_pkg::CH_W-1:0]       head_dim;
  logic [15:0]                     out_limit;
  logic                            cfg_range_ok;

  // Loop counters; k_idx also counts output columns.
  logic [mhaf_pkg::CH_W-1:0]       base;
  logic [mhaf_pkg::SEQ_AW-1:0]     i_idx;
  logic [mhaf_pkg::SEQ_AW-1:0]     j_idx;
  logic [mhaf_pkg::HDIM_AW-1:0]    k_idx;
  logic [mhaf_pkg::SEQ_AW-1:0]     t_last;
  logic [mhaf_pkg::HDIM_AW-1:0]    h_last;
  logic                            run_last;

  // Datapath registers.
  logic signed [15:0]              q_reg;
  logic signed [39:0]              acc;
  logic signed [39:0]              acc_next;
  logic [31:0]                     p_lo;
  logic signed [40:0]              p_hi;
  logic signed [mhaf_pkg::SCORE_W-1:0] row_max;
  logic [mhaf_pkg::SUM_W-1:0]      exp_sum;
  logic signed [39:0]              acc_o;

  // Combinational datapath.
  logic signed [31:0]              prod;
  logic signed [23:0]              acc_hi;
  logic signed [16:0]              scale_s;
  logic signed [56:0]              scaled;
  logic signed [mhaf_pkg::SCORE_W-1:0] score_val;
  logic signed [32:0]              diff;
  logic [32:0]                     diff_u;
  logic                            exp_hit;
  logic [mhaf_pkg::EXP_ONE_W-1:0]  e_val;
  logic signed [33:0]              prod_o;
  logic signed [39:0]              rnd;
  logic signed [15:0]              sat_val;

  // Addresses.
  logic [10:0]                     row_len;
  logic [mhaf_pkg::QKV_AW:0]       i_row;
  logic [mhaf_pkg::QKV_AW:0]       j_row;
  logic [mhaf_pkg::QKV_AW:0]       q_addr;
  logic [mhaf_pkg::QKV_AW:0]       k_addr;
  logic [mhaf_pkg::QKV_AW:0]       v_addr;
  logic [15:0]                     o_addr;

  // Memory ports.
  logic                            qkv_we;
  logic [mhaf_pkg::QKV_AW-1:0]     qkv_raddr;
  logic [15:0]                     qkv_rdata;
  logic                            out_we;
  logic [15:0]                     out_rdata;
  logic                            sc_we;
  logic [mhaf_pkg::SCORE_W-1:0]    sc_wdata;
  logic [mhaf_pkg::SCORE_W-1:0]    sc_rdata;

  // Divider.
  logic                            div_start;
  logic [mhaf_pkg::DIV_NUM_W-1:0]  div_num;
  logic [mhaf_pkg::DIV_DEN_W-1:0]  div_den;
  logic                            div_busy;
  logic                            div_done;
  logic [mhaf_pkg::DIV_NUM_W-1:0]  div_quo;
  logic [mhaf_pkg::DIV_DEN_W-1:0]  div_rem;

  // Handshake.
  logic                            in_fire;
  logic                            out_load;
  mhaf_pkg::out_word_t             out_next;

  assign in_ready = (state == S_IDLE) && !cfg_dirty && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;

  assign cfg_range_ok = (seq_len >= 7'd1) && (seq_len <= 7'(mhaf_pkg::MAX_SEQ)) &&
                        (channels >= 9'd1) && (channels <= 9'(mhaf_pkg::MAX_CHANNELS)) &&
                        (head_count >= 5'd1) && (head_count <= 5'(mhaf_pkg::MAX_HEADS));

  assign t_last   = mhaf_pkg::SEQ_AW'(seq_len - 7'd1);
  assign h_last   = mhaf_pkg::HDIM_AW'(head_dim - 1'b1);
  assign run_last = (k_idx == h_last) && (i_idx == t_last) &&
                    (10'(base) + 10'(head_dim) == 10'(channels));

  assign row_len = 11'({channels, 1'b0}) + 11'(channels);
  assign i_row   = (mhaf_pkg::QKV_AW+1)'(i_idx) * (mhaf_pkg::QKV_AW+1)'(row_len);
  assign j_row   = (mhaf_pkg::QKV_AW+1)'(j_idx) * (mhaf_pkg::QKV_AW+1)'(row_len);
  assign q_addr  = i_row + (mhaf_pkg::QKV_AW+1)'(base) + (mhaf_pkg::QKV_AW+1)'(k_idx);
  assign k_addr  = j_row + (mhaf_pkg::QKV_AW+1)'(channels) +
                   (mhaf_pkg::QKV_AW+1)'(base) + (mhaf_pkg::QKV_AW+1)'(k_idx);
  assign v_addr  = j_row + (mhaf_pkg::QKV_AW+1)'({channels, 1'b0}) +
                   (mhaf_pkg::QKV_AW+1)'(base) + (mhaf_pkg::QKV_AW+1)'(k_idx);
  assign o_addr  = 16'(i_idx) * 16'(channels) + 16'(base) + 16'(k_idx);

  always_comb begin
    case (state)
      S_K:     qkv_raddr = k_addr[mhaf_pkg::QKV_AW-1:0];
      S_O_RD:  qkv_raddr = v_addr[mhaf_pkg::QKV_AW-1:0];
      default: qkv_raddr = q_addr[mhaf_pkg::QKV_AW-1:0];
    endcase
  end

  assign qkv_we = in_fire && (in_word.func == mhaf_pkg::FUNC_LOAD) &&
                  (in_word.elem_index < 16'(mhaf_pkg::QKV_DEPTH));

  // Dot product step and the split scale multiplication.
  assign prod     = q_reg * signed'(qkv_rdata);
  assign acc_next = ((k_idx == '0) ? 40'sd0 : acc) + 40'(prod);
  assign acc_hi   = acc[39:16];
  assign scale_s  = signed'({1'b0, score_scale});
  assign scaled   = signed'({p_hi, 16'b0}) + signed'(57'(p_lo));
  assign score_val = mhaf_pkg::SCORE_W'(scaled >>> 28);

  // Distance below the row maximum picks the exp table entry.
  assign diff    = 33'(row_max) - 33'(signed'(sc_rdata));
  assign diff_u  = diff;
  assign exp_hit = (diff_u >> 8) < 33'(mhaf_pkg::EXP_TABLE_DEPTH);
  assign e_val   = exp_hit ? mhaf_pkg::EXP_TABLE[diff_u[8 +: mhaf_pkg::EXP_IDX_W]] : '0;

  assign prod_o = signed'({1'b0, sc_rdata[mhaf_pkg::EXP_ONE_W-1:0]}) * signed'(qkv_rdata);
  assign rnd    = (acc_o + 40'sd32768) >>> 16;

  always_comb begin
    if (rnd > 40'sd32767) begin
      sat_val = 16'sh7fff;
    end else if (rnd < -40'sd32768) begin
      sat_val = -16'sh8000;
    end else begin
      sat_val = 16'(rnd);
    end
  end

  always_comb begin
    case (state)
      S_SC2:   sc_wdata = score_val;
      S_EXP:   sc_wdata = mhaf_pkg::SCORE_W'(e_val);
      default: sc_wdata = mhaf_pkg::SCORE_W'(div_quo[mhaf_pkg::EXP_ONE_W-1:0]);
    endcase
  end

  assign sc_we  = (state == S_SC2) || (state == S_EXP) || ((state == S_W_WAIT) && div_done);
  assign out_we = (state == S_O_WR);

  // The divider serves the configuration check and the weight normalisation.
  assign div_start = (state == S_CHK) || (state == S_W_DIV);
  assign div_num   = (state == S_CHK) ? mhaf_pkg::DIV_NUM_W'(channels)
                   : {sc_rdata[mhaf_pkg::EXP_ONE_W-1:0], 16'b0} +
                     mhaf_pkg::DIV_NUM_W'(exp_sum >> 1);
  assign div_den   = (state == S_CHK) ? mhaf_pkg::DIV_DEN_W'(head_count) : exp_sum;

  always_comb begin
    out_load = 1'b0;
    out_next = '{out_value: 16'sd0, status: mhaf_pkg::STATUS_OK};
    if (in_fire) begin
      case (in_word.func)
        mhaf_pkg::FUNC_LOAD: begin
          out_load = 1'b1;
          if (!qkv_we) begin
            out_next.status = mhaf_pkg::STATUS_RANGE;
          end
        end
        mhaf_pkg::FUNC_RUN: begin
          if (!cfg_ok) begin
            out_load = 1'b1;
            out_next.status = mhaf_pkg::STATUS_BAD_CFG;
          end
        end
        mhaf_pkg::FUNC_READ: begin
          if (!cfg_ok) begin
            out_load = 1'b1;
            out_next.status = mhaf_pkg::STATUS_BAD_CFG;
          end else if (in_word.elem_index >= out_limit) begin
            out_load = 1'b1;
            out_next.status = mhaf_pkg::STATUS_RANGE;
          end
        end
        default: out_load = 1'b0;
      endcase
    end
    if (state == S_READ) begin
      out_load = 1'b1;
      out_next.out_value = signed'(out_rdata);
    end
    if ((state == S_O_WR) && run_last) begin
      out_load = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      seq_len     <= 7'd8;
      channels    <= 9'd64;
      head_count  <= 5'd4;
      score_scale <= 16'd16384;
      cfg_dirty   <= 1'b1;
      cfg_ok      <= 1'b0;
      head_dim    <= '0;
      out_limit   <= '0;
      base        <= '0;
      i_idx       <= '0;
      j_idx       <= '0;
      k_idx       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_dirty) begin
            state <= S_CHK;
          end else if (in_fire) begin
            if ((in_word.func == mhaf_pkg::FUNC_RUN) && cfg_ok) begin
              base  <= '0;
              i_idx <= '0;
              j_idx <= '0;
              k_idx <= '0;
              state <= S_Q;
            end else if ((in_word.func == mhaf_pkg::FUNC_READ) && cfg_ok &&
                         (in_word.elem_index < out_limit)) begin
              state <= S_READ;
            end
          end
        end
        S_CHK: begin
          cfg_dirty <= 1'b0;
          state     <= S_CHKW;
        end
        S_CHKW: begin
          if (div_done) begin
            head_dim  <= mhaf_pkg::CH_W'(div_quo);
            cfg_ok    <= cfg_range_ok && (div_rem == '0);
            out_limit <= 16'(seq_len) * 16'(channels);
            state     <= S_IDLE;
          end
        end
        S_READ: state <= S_IDLE;
        S_Q: state <= S_K;
        S_K: begin
          q_reg <= signed'(qkv_rdata);
          state <= S_MAC;
        end
        S_MAC: begin
          acc <= acc_next;
          if (k_idx == h_last) begin
            state <= S_SC1;
          end else begin
            k_idx <= k_idx + 1'b1;
            state <= S_Q;
          end
        end
        S_SC1: begin
          p_lo  <= 32'(acc[15:0]) * 32'(score_scale);
          p_hi  <= 41'(acc_hi * scale_s);
          state <= S_SC2;
        end
        S_SC2: begin
          if ((j_idx == '0) || (score_val > row_max)) begin
            row_max <= score_val;
          end
          k_idx <= '0;
          if (j_idx == t_last) begin
            j_idx <= '0;
            state <= S_EXP_RD;
          end else begin
            j_idx <= j_idx + 1'b1;
            state <= S_Q;
          end
        end
        S_EXP_RD: state <= S_EXP;
        S_EXP: begin
          exp_sum <= ((j_idx == '0) ? '0 : exp_sum) + mhaf_pkg::SUM_W'(e_val);
          if (j_idx == t_last) begin
            j_idx <= '0;
            state <= S_W_RD;
          end else begin
            j_idx <= j_idx + 1'b1;
            state <= S_EXP_RD;
          end
        end
        S_W_RD: state <= S_W_DIV;
        S_W_DIV: state <= S_W_WAIT;
        S_W_WAIT: begin
          if (div_done) begin
            if (j_idx == t_last) begin
              j_idx <= '0;
              k_idx <= '0;
              state <= S_O_RD;
            end else begin
              j_idx <= j_idx + 1'b1;
              state <= S_W_RD;
            end
          end
        end
        S_O_RD: state <= S_O_MAC;
        S_O_MAC: begin
          acc_o <= ((j_idx == '0) ? 40'sd0 : acc_o) + 40'(prod_o);
          if (j_idx == t_last) begin
            state <= S_O_WR;
          end else begin
            j_idx <= j_idx + 1'b1;
            state <= S_O_RD;
          end
        end
        S_O_WR: begin
          j_idx <= '0;
          if (k_idx == h_last) begin
            k_idx <= '0;
            if (i_idx == t_last) begin
              i_idx <= '0;
              if (run_last) begin
                state <= S_IDLE;
              end else begin
                base  <= base + head_dim;
                state <= S_Q;
              end
            end else begin
              i_idx <= i_idx + 1'b1;
              state <= S_Q;
            end
          end else begin
            k_idx <= k_idx + 1'b1;
            state <= S_O_RD;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (cfg_wr_en) begin
        cfg_dirty <= 1'b1;
        case (mhaf_pkg::reg_index_t'(cfg_addr))
          mhaf_pkg::REG_SEQ_LEN:     seq_len     <= cfg_wr_data[6:0];
          mhaf_pkg::REG_CHANNELS:    channels    <= cfg_wr_data[8:0];
          mhaf_pkg::REG_HEAD_COUNT:  head_count  <= cfg_wr_data[4:0];
          mhaf_pkg::REG_SCORE_SCALE: score_scale <= cfg_wr_data;
          default:                   cfg_dirty   <= 1'b1;
        endcase
      end
    end
  end

  mhaf_ram #(
    .WIDTH(16),
    .DEPTH(mhaf_pkg::QKV_DEPTH)
  ) u_qkv_ram (
    .clk  (clk),
    .we   (qkv_we),
    .waddr(in_word.elem_index[mhaf_pkg::QKV_AW-1:0]),
    .wdata(in_word.elem_value),
    .raddr(qkv_raddr),
    .rdata(qkv_rdata)
  );

  mhaf_ram #(
    .WIDTH(16),
    .DEPTH(mhaf_pkg::OUT_DEPTH)
  ) u_out_ram (
    .clk  (clk),
    .we   (out_we),
    .waddr(o_addr[mhaf_pkg::OUT_AW-1:0]),
    .wdata(sat_val),
    .raddr(in_word.elem_index[mhaf_pkg::OUT_AW-1:0]),
    .rdata(out_rdata)
  );

  mhaf_ram #(
    .WIDTH(mhaf_pkg::SCORE_W),
    .DEPTH(mhaf_pkg::MAX_SEQ)
  ) u_score_ram (
    .clk  (clk),
    .we   (sc_we),
    .waddr(j_idx),
    .wdata(sc_wdata),
    .raddr(j_idx),
    .rdata(sc_rdata)
  );

  mhaf_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .done (div_done),
    .quo  (div_quo),
    .rem  (div_rem)
  );

`include "multi_head_attention_forward_core_assert.svh"

  `MHAF_ASSERT_NOW(a_out_not_overwritten, out_load, !out_valid || out_ready, "result word overwritten before it was taken")
  `MHAF_ASSERT_NOW(a_div_start_free, div_start, !div_busy, "divider restarted while busy")
  `MHAF_ASSERT_NEXT(a_run_holds_result, in_fire && (in_word.func == mhaf_pkg::FUNC_RUN) && cfg_ok, !out_valid, "run answered before the computation")

endmodule

### bench/multi_head_attention_forward_core_tb.sv
// Self-checking bench for the attention core: loads Q,K,V words, runs and reads back.
// Depends on mhaf_pkg and multi_head_attention_forward_core; expected words come
// from a fixed-point attention model kept inside the bench.
module multi_head_attention_forward_core_tb;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  mhaf_pkg::in_word_t            in_word;
  logic                          out_valid;
  logic                          out_ready;
  mhaf_pkg::out_word_t           out_word;
  logic                          cfg_wr_en;
  logic [mhaf_pkg::CFG_AW-1:0]   cfg_addr;
  logic [mhaf_pkg::CFG_DW-1:0]   cfg_wr_data;

  multi_head_attention_forward_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Model state.
  logic signed [15:0] qkv_mem [mhaf_pkg::QKV_DEPTH];
  logic signed [15:0] attn_out_mem [mhaf_pkg::OUT_DEPTH];
  longint             exp_lut [mhaf_pkg::EXP_TABLE_DEPTH];
  int unsigned        m_seq, m_ch, m_heads, m_scale;

  mhaf_pkg::out_word_t pending_results [$];
  int        mismatch_count;
  int        items_sent;
  bit        hold_req;
  bit        hold_used;
  int        hold_left;
  bit        smooth_rx;

  function automatic void build_exp_lut();
    logic [95:0] x;
    x = 96'd1 << 32;
    for (int i = 0; i < mhaf_pkg::EXP_TABLE_DEPTH; i++) begin
      exp_lut[i] = longint'((x + 96'd32768) >> 16);
      x = ((x * 96'd4034748381) + (96'd1 << 31)) >> 32;
    end
  endfunction

  function automatic bit shape_ok();
    if (m_seq < 1 || m_seq > mhaf_pkg::MAX_SEQ) return 0;
    if (m_ch < 1 || m_ch > mhaf_pkg::MAX_CHANNELS) return 0;
    if (m_heads < 1 || m_heads > mhaf_pkg::MAX_HEADS) return 0;
    return (m_ch % m_heads) == 0;
  endfunction

  function automatic void model_attention();
    int     t_n, c_n, h_n, row, base;
    longint dot, s, mx, sum, o, r;
    longint score [mhaf_pkg::MAX_SEQ];
    longint wt [mhaf_pkg::MAX_SEQ];
    longint idx;
    t_n = m_seq;
    c_n = m_ch;
    h_n = m_ch / m_heads;
    row = 3 * c_n;
    for (int hd = 0; hd < int'(m_heads); hd++) begin
      base = hd * h_n;
      for (int i = 0; i < t_n; i++) begin
        mx = -(64'sd1 <<< 62);
        for (int j = 0; j < t_n; j++) begin
          dot = 0;
          for (int k = 0; k < h_n; k++)
            dot += longint'(qkv_mem[i*row + base + k]) *
                   longint'(qkv_mem[j*row + c_n + base + k]);
          s = (dot * longint'(m_scale)) >>> 28;
          if (s > 64'sd2147483647) s = 64'sd2147483647;
          if (s < -64'sd2147483648) s = -64'sd2147483648;
          score[j] = s;
          if (s > mx) mx = s;
        end
        sum = 0;
        for (int j = 0; j < t_n; j++) begin
          idx = (mx - score[j]) >>> 8;
          wt[j] = (idx < mhaf_pkg::EXP_TABLE_DEPTH) ? exp_lut[idx] : 0;
          sum += wt[j];
        end
        for (int j = 0; j < t_n; j++)
          wt[j] = ((wt[j] <<< 16) + sum / 2) / sum;
        for (int c = 0; c < h_n; c++) begin
          o = 0;
          for (int j = 0; j < t_n; j++)
            o += wt[j] * longint'(qkv_mem[j*row + 2*c_n + base + c]);
          r = (o + 32768) >>> 16;
          if (r > 32767) r = 32767;
          if (r < -32768) r = -32768;
          attn_out_mem[i*c_n + base + c] = 16'(r);
        end
      end
    end
  endfunction

  // Sender gap: mostly none, now and then a short one, rarely a long one.
  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 30);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_word(mhaf_pkg::func_t f, logic [15:0] idx, logic signed [15:0] val);
    mhaf_pkg::out_word_t ow;
    sender_gap();
    in_valid <= 1'b1;
    in_word  <= '{func: f, elem_index: idx, elem_value: val};
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    ow.out_value = '0;
    ow.status    = mhaf_pkg::STATUS_OK;
    case (f)
      mhaf_pkg::FUNC_LOAD: begin
        if (idx < mhaf_pkg::QKV_DEPTH) qkv_mem[idx] = val;
        else ow.status = mhaf_pkg::STATUS_RANGE;
      end
      mhaf_pkg::FUNC_RUN: begin
        if (shape_ok()) model_attention();
        else ow.status = mhaf_pkg::STATUS_BAD_CFG;
      end
      mhaf_pkg::FUNC_READ: begin
        if (!shape_ok()) ow.status = mhaf_pkg::STATUS_BAD_CFG;
        else if (idx >= m_seq * m_ch) ow.status = mhaf_pkg::STATUS_RANGE;
        else ow.out_value = attn_out_mem[idx];
      end
      default: ;
    endcase
    if (f != mhaf_pkg::FUNC_NONE) begin
      pending_results.push_back(ow);
      items_sent++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(mhaf_pkg::reg_index_t r, int unsigned v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= r;
    cfg_wr_data <= 16'(v);
    case (r)
      mhaf_pkg::REG_SEQ_LEN:    m_seq   = v & 32'h7F;
      mhaf_pkg::REG_CHANNELS:   m_ch    = v & 32'h1FF;
      mhaf_pkg::REG_HEAD_COUNT: m_heads = v & 32'h1F;
      default:                  m_scale = v & 32'hFFFF;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_shape(int unsigned t, int unsigned c, int unsigned nh, int unsigned sc);
    drain();
    write_reg(mhaf_pkg::REG_SEQ_LEN, t);
    write_reg(mhaf_pkg::REG_CHANNELS, c);
    write_reg(mhaf_pkg::REG_HEAD_COUNT, nh);
    write_reg(mhaf_pkg::REG_SCORE_SCALE, sc);
  endtask

  function automatic logic signed [15:0] pick_value(int amp);
    if (amp >= 32768) return 16'($urandom_range(0, 65535));
    return 16'(int'($urandom_range(0, 2 * amp)) - amp);
  endfunction

  // Loads every Q,K,V element the current shape uses, with some stray words mixed in when noise is set.
  task automatic fill_qkv(int amp, bit noise);
    int n;
    n = 3 * m_seq * m_ch;
    for (int i = 0; i < n; i++) begin
      if (noise && $urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 1))
          0: send_word(mhaf_pkg::FUNC_NONE, 16'($urandom), 16'($urandom));
          default: send_word(mhaf_pkg::FUNC_LOAD,
                             16'($urandom_range(mhaf_pkg::QKV_DEPTH, 65535)), 16'($urandom));
        endcase
      end
      send_word(mhaf_pkg::FUNC_LOAD, 16'(i), pick_value(amp));
    end
  endtask

  task automatic read_back(int count);
    int lim;
    lim = m_seq * m_ch;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0)
        send_word(mhaf_pkg::FUNC_READ, 16'($urandom_range(lim, 65535)), 16'($urandom));
      else
        send_word(mhaf_pkg::FUNC_READ, 16'($urandom_range(0, lim - 1)), 16'($urandom));
    end
  endtask

  task automatic test_directed();
    // Reset shape: words that never touch an unwritten entry.
    send_word(mhaf_pkg::FUNC_LOAD, 16'(mhaf_pkg::QKV_DEPTH), 16'sh7FFF);
    send_word(mhaf_pkg::FUNC_LOAD, 16'hFFFF, -16'sh8000);
    send_word(mhaf_pkg::FUNC_NONE, 16'h0000, 16'sh0000);
    send_word(mhaf_pkg::FUNC_READ, 16'd512, 16'sh0000);
    send_word(mhaf_pkg::FUNC_READ, 16'hFFFF, 16'shFFFF);
    set_shape(1, 1, 1, 65535);
    send_word(mhaf_pkg::FUNC_LOAD, 16'd0, -16'sh8000);
    send_word(mhaf_pkg::FUNC_LOAD, 16'd1, 16'sh7FFF);
    send_word(mhaf_pkg::FUNC_LOAD, 16'd2, 16'sh7FFF);
    send_word(mhaf_pkg::FUNC_RUN, 16'hFFFF, 16'shFFFF);
    send_word(mhaf_pkg::FUNC_READ, 16'd0, 16'sh0000);
    send_word(mhaf_pkg::FUNC_READ, 16'd1, 16'sh0000);
  endtask

  task automatic test_bad_config();
    int unsigned bad [7][3] = '{'{0, 4, 2}, '{65, 4, 2}, '{127, 4, 2}, '{2, 0, 1},
                                '{2, 257, 1}, '{2, 4, 0}, '{2, 6, 4}};
    foreach (bad[i]) begin
      set_shape(bad[i][0], bad[i][1], bad[i][2], $urandom_range(0, 65535));
      send_word(mhaf_pkg::FUNC_RUN, 16'd0, 16'sh0000);
      send_word(mhaf_pkg::FUNC_READ, 16'd0, 16'sh0000);
    end
    set_shape(2, 511, 17, 0);
    send_word(mhaf_pkg::FUNC_RUN, 16'd0, 16'sh0000);
  endtask

  task automatic test_extremes();
    set_shape(mhaf_pkg::MAX_SEQ, 1, 1, 65535);
    fill_qkv(32768, 0);
    send_word(mhaf_pkg::FUNC_RUN, 16'd0, 16'sh0000);
    read_back(8);
    set_shape(1, 48, mhaf_pkg::MAX_HEADS, 16384);
    fill_qkv(4096, 0);
    send_word(mhaf_pkg::FUNC_RUN, 16'd0, 16'sh0000);
    read_back(8);
    set_shape(1, 48, 1, 0);
    send_word(mhaf_pkg::FUNC_RUN, 16'd0, 16'sh0000);
    read_back(8);
  endtask

  task automatic test_random();
    int unsigned t, nh, c, sc;
    int amp;
    int phase;
    phase = 0;
    while (items_sent < 330) begin
      phase++;
      if ($urandom_range(0, 7) == 0) begin
        set_shape($urandom_range(0, 127), $urandom_range(0, 511), $urandom_range(0, 31),
                  $urandom_range(0, 65535));
        // A random shape that happens to be legal would run on entries never loaded.
        if (!shape_ok()) begin
          send_word(mhaf_pkg::FUNC_RUN, 16'($urandom), 16'($urandom));
          send_word(mhaf_pkg::FUNC_READ, 16'($urandom), 16'($urandom));
        end
        send_word(mhaf_pkg::FUNC_LOAD, 16'($urandom), 16'($urandom));
      end else begin
        t  = $urandom_range(1, 4);
        nh = 1 << $urandom_range(0, 2);
        c  = nh * $urandom_range(1, 3);
        case ($urandom_range(0, 5))
          0:       sc = 0;
          1:       sc = 65535;
          default: sc = $urandom_range(0, 65535);
        endcase
        set_shape(t, c, nh, sc);
        case ($urandom_range(0, 2))
          0:       amp = 32768;
          1:       amp = 4096;
          default: amp = 256;
        endcase
        // Once, the receiver stalls for a long stretch while words keep coming.
        if (!hold_used && phase >= 3) begin
          hold_req  = 1'b1;
          hold_used = 1'b1;
        end
        fill_qkv(amp, 1);
        send_word(mhaf_pkg::FUNC_RUN, 16'($urandom), 16'($urandom));
        read_back($urandom_range(4, 12));
      end
    end
  endtask

  // Receiver: random ready, occasional long holds, some stretches always ready.
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) smooth_rx = !smooth_rx;
    if (hold_req && hold_left == 0) begin
      hold_req  = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (smooth_rx) begin
      out_ready <= 1'b1;
    end else begin
      if ($urandom_range(0, 99) == 0) hold_left = $urandom_range(10, 40);
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // A word seen with valid and ready at the falling edge is taken at the next rising edge.
  always @(negedge clk) begin
    mhaf_pkg::out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result word value %0d status %0d", $time,
                 out_word.out_value, out_word.status);
      end else begin
        want = pending_results.pop_front();
        if (want.out_value !== out_word.out_value) begin
          mismatch_count++;
          $display("%0t: out_value expected %0d actual %0d", $time,
                   want.out_value, out_word.out_value);
        end
        if (want.status !== out_word.status) begin
          mismatch_count++;
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, out_word.status);
        end
      end
    end
  end

  initial begin
    #100000000;
    $display("multi_head_attention_forward_core: mismatch");
    $finish;
  end

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    in_word     <= '{func: mhaf_pkg::FUNC_LOAD, elem_index: 16'd0, elem_value: 16'sd0};
    cfg_wr_en   <= 1'b0;
    cfg_addr    <= '0;
    cfg_wr_data <= '0;
    out_ready   <= 1'b0;
    mismatch_count = 0;
    items_sent     = 0;
    hold_req       = 1'b0;
    hold_used      = 1'b0;
    hold_left      = 0;
    smooth_rx      = 1'b0;
    m_seq   = 8;
    m_ch    = 64;
    m_heads = 4;
    m_scale = 16384;
    build_exp_lut();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_bad_config();
    test_random();
    test_extremes();
    drain();
    if (mismatch_count == 0) begin
      $display("multi_head_attention_forward_core: match");
    end else begin
      $display("multi_head_attention_forward_core: mismatch");
    end
    $finish;
  end

endmodule
